/* hdl/bcfr_pkg.sv */
// shared types, constants and helpers of the block cache tag controller
// no dependencies; imported by the cell, controller, top level and checker
`default_nettype none

package bcfr_pkg;

    // geometry
    localparam int SLOTS  = 16;
    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int BLK_W  = 16;
    localparam int SEQ_W  = 8;
    localparam int SLOT_W = 4;

    // sequence constants
    localparam logic [SEQ_W-1:0] SEQ_MAX = 8'd255;
    localparam logic [SEQ_W-1:0] SEQ_ONE = 8'h01;

    // stream widths and result field positions in tdata
    localparam int IN_USER_W  = 2;
    localparam int OUT_USER_W = 3;
    localparam int OUT_DATA_W = 24;
    localparam int WB_BIT     = SLOT_W;
    localparam int VIC_LSB    = SLOT_W + 1;
    localparam int VIC_MSB    = VIC_LSB + BLK_W - 1;
    localparam int PAD_W      = OUT_DATA_W - VIC_MSB - 1;

    // request codes
    typedef enum logic [IN_USER_W-1:0] {
        OP_ACCESS       = 2'd0,
        OP_ACCESS_DIRTY = 2'd1,
        OP_FLUSH        = 2'd2,
        OP_NONE         = 2'd3
    } t_op;

    // result codes
    typedef enum logic [OUT_USER_W-1:0] {
        KIND_NULL       = 3'd0,
        KIND_HIT        = 3'd1,
        KIND_MISS       = 3'd2,
        KIND_FLUSH_WB   = 3'd3,
        KIND_FLUSH_NONE = 3'd4
    } t_kind;

    // scan record carried from cell to cell
    typedef struct packed {
        logic             flush;
        logic             mark;
        logic [BLK_W-1:0] blk;
        logic             found;
        logic [IDX_W-1:0] hit_idx;
        logic             stop;
        logic [IDX_W-1:0] vic_idx;
        logic [BLK_W-1:0] vic_blk;
        logic             vic_dirty;
        logic             have_min;
        logic [SEQ_W-1:0] min_seq;
        logic [SEQ_W-1:0] max_seq;
    } t_rec;

    typedef struct packed {
        logic valid;
        t_rec rec;
    } t_tok;

    // flush writeback offered by the cell holding the token
    typedef struct packed {
        logic             req;
        logic [IDX_W-1:0] idx;
        logic [BLK_W-1:0] blk;
    } t_emit;

    // state update broadcast to all cells
    typedef struct packed {
        logic             fill;
        logic             mark;
        logic [IDX_W-1:0] idx;
        logic [BLK_W-1:0] blk;
        logic [SEQ_W-1:0] seq;
        logic             dirty;
    } t_cmt;

    // one result
    typedef struct packed {
        t_kind             kind;
        logic [SLOT_W-1:0] slot;
        logic              wb;
        logic [BLK_W-1:0]  victim;
        logic              last;
    } t_res;

    // slot field keeps the low bits of the index
    function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
        logic [SLOT_W+IDX_W-1:0] v;
        v = {{SLOT_W{1'b0}}, idx};
        return v[SLOT_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* hdl/bcfr_cell.sv */
// one cache slot: tag, fill sequence and dirty mark, plus the scan stage
// depends on bcfr_pkg
`default_nettype none

module bcfr_cell (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [bcfr_pkg::IDX_W-1:0] i_idx,
    input  wire bcfr_pkg::t_tok            i_tok,
    output bcfr_pkg::t_tok                 o_tok,
    input  wire bcfr_pkg::t_cmt            i_cmt,
    input  wire logic                      i_ack,
    output bcfr_pkg::t_emit                o_emit
);
    import bcfr_pkg::*;

    logic             r_valid, n_valid;
    t_rec             r_rec;
    logic [BLK_W-1:0] r_blk, n_blk;
    logic [SEQ_W-1:0] r_seq, n_seq;
    logic             r_dirty, n_dirty;
    logic             w_hold;
    logic             w_sel;
    t_rec             w_rec;

    // a flush token waits here while this slot is dirty
    assign w_hold = r_valid && r_rec.flush && r_dirty;

    // scan step of an access
    always_comb begin
        w_rec = r_rec;
        if (!r_rec.flush && !r_rec.found && !r_rec.stop) begin
            priority if (r_blk == r_rec.blk) begin
                w_rec.found   = 1'b1;
                w_rec.hit_idx = i_idx;
            end else if (r_blk == '0) begin
                w_rec.stop      = 1'b1;
                w_rec.vic_idx   = i_idx;
                w_rec.vic_blk   = r_blk;
                w_rec.vic_dirty = r_dirty;
            end else begin
                if (!r_rec.have_min || (r_seq < r_rec.min_seq)) begin
                    w_rec.have_min  = 1'b1;
                    w_rec.min_seq   = r_seq;
                    w_rec.vic_idx   = i_idx;
                    w_rec.vic_blk   = r_blk;
                    w_rec.vic_dirty = r_dirty;
                end
                if (r_seq > r_rec.max_seq) begin
                    w_rec.max_seq = r_seq;
                end
            end
        end
    end

    // hand the token on unless held for a writeback
    assign o_tok.valid = r_valid && !w_hold;
    assign o_tok.rec   = w_rec;

    // writeback offer, zero when idle so the bus can be or-ed
    assign o_emit.req = w_hold;
    assign o_emit.idx = w_hold ? i_idx : '0;
    assign o_emit.blk = w_hold ? r_blk : '0;

    // slot state next values
    assign w_sel = (i_cmt.idx == i_idx);

    always_comb begin
        n_valid = i_tok.valid || w_hold;
        n_blk   = r_blk;
        n_seq   = r_seq;
        n_dirty = r_dirty;
        priority if (i_cmt.fill && w_sel) begin
            n_blk   = i_cmt.blk;
            n_seq   = i_cmt.seq;
            n_dirty = i_cmt.dirty;
        end else if (i_cmt.mark && w_sel) begin
            n_dirty = 1'b1;
        end
        if (w_hold && i_ack) begin
            n_dirty = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_blk   <= '0;
            r_seq   <= '0;
            r_dirty <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_blk   <= n_blk;
            r_seq   <= n_seq;
            r_dirty <= n_dirty;
        end
    end

    // token payload
    always_ff @(posedge i_clk) begin
        if (i_tok.valid) begin
            r_rec <= i_tok.rec;
        end
    end

endmodule

`default_nettype wire

/* hdl/bcfr_ctrl.sv */
// request decode, scan launch, commit, flush sequencing and output register
// depends on bcfr_pkg
`default_nettype none

module bcfr_ctrl (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_s_valid,
    output logic                           o_s_ready,
    input  wire bcfr_pkg::t_op             i_s_op,
    input  wire logic [bcfr_pkg::BLK_W-1:0] i_s_blk,
    output bcfr_pkg::t_tok                 o_tok,
    input  wire bcfr_pkg::t_tok            i_tok,
    input  wire bcfr_pkg::t_emit           i_emit,
    output logic                           o_ack,
    output bcfr_pkg::t_cmt                 o_cmt,
    output logic                           o_m_valid,
    input  wire logic                      i_m_ready,
    output bcfr_pkg::t_res                 o_m_res
);
    import bcfr_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_FLUSH = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    t_res   r_res, n_res;
    t_res   r_out, n_out;
    logic   r_out_valid, n_out_valid;
    t_emit  r_pend, n_pend;
    logic   r_pend_valid, n_pend_valid;
    logic   w_out_free;
    t_rec   w_rec;

    assign w_out_free = !r_out_valid || i_m_ready;
    assign o_s_ready  = (r_state == ST_IDLE);
    assign w_rec      = i_tok.rec;

    always_comb begin
        n_state      = r_state;
        n_res        = r_res;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !i_m_ready;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        o_ack        = 1'b0;
        o_cmt        = '0;

        // fresh scan record
        o_tok               = '0;
        o_tok.rec.flush     = (i_s_op == OP_FLUSH);
        o_tok.rec.mark      = (i_s_op == OP_ACCESS_DIRTY);
        o_tok.rec.blk       = i_s_blk;
        o_tok.rec.min_seq   = SEQ_MAX;

        unique case (r_state)
            // decode a new request
            ST_IDLE: begin
                if (i_s_valid) begin
                    unique case (i_s_op)
                        OP_ACCESS, OP_ACCESS_DIRTY: begin
                            if (i_s_blk == '0) begin
                                n_res.kind   = KIND_NULL;
                                n_res.slot   = '0;
                                n_res.wb     = 1'b0;
                                n_res.victim = '0;
                                n_res.last   = 1'b1;
                                n_state      = ST_DONE;
                            end else begin
                                o_tok.valid = 1'b1;
                                n_state     = ST_SCAN;
                            end
                        end
                        OP_FLUSH: begin
                            o_tok.valid = 1'b1;
                            n_state     = ST_FLUSH;
                        end
                        OP_NONE: begin
                            n_state = ST_IDLE;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            // scan came out of the last cell: decide and update the slot
            ST_SCAN: begin
                if (i_tok.valid) begin
                    n_res.last = 1'b1;
                    if (w_rec.found) begin
                        n_res.kind   = KIND_HIT;
                        n_res.slot   = to_slot(w_rec.hit_idx);
                        n_res.wb     = 1'b0;
                        n_res.victim = '0;
                        o_cmt.mark   = w_rec.mark;
                        o_cmt.idx    = w_rec.hit_idx;
                    end else begin
                        n_res.kind   = KIND_MISS;
                        n_res.slot   = to_slot(w_rec.vic_idx);
                        n_res.wb     = w_rec.vic_dirty;
                        n_res.victim = w_rec.vic_dirty ? w_rec.vic_blk : '0;
                        o_cmt.fill   = 1'b1;
                        o_cmt.idx    = w_rec.vic_idx;
                        o_cmt.blk    = w_rec.blk;
                        o_cmt.seq    = w_rec.max_seq + SEQ_ONE;
                        o_cmt.dirty  = w_rec.mark;
                    end
                    n_state = ST_DONE;
                end
            end
            // flush: keep one writeback back so the final one carries last
            ST_FLUSH: begin
                if (i_emit.req && (!r_pend_valid || w_out_free)) begin
                    o_ack        = 1'b1;
                    n_pend       = i_emit;
                    n_pend_valid = 1'b1;
                    if (r_pend_valid) begin
                        n_out.kind   = KIND_FLUSH_WB;
                        n_out.slot   = to_slot(r_pend.idx);
                        n_out.wb     = 1'b1;
                        n_out.victim = r_pend.blk;
                        n_out.last   = 1'b0;
                        n_out_valid  = 1'b1;
                    end
                end
                if (i_tok.valid) begin
                    n_res.last = 1'b1;
                    if (r_pend_valid) begin
                        n_res.kind   = KIND_FLUSH_WB;
                        n_res.slot   = to_slot(r_pend.idx);
                        n_res.wb     = 1'b1;
                        n_res.victim = r_pend.blk;
                    end else begin
                        n_res.kind   = KIND_FLUSH_NONE;
                        n_res.slot   = '0;
                        n_res.wb     = 1'b0;
                        n_res.victim = '0;
                    end
                    n_pend_valid = 1'b0;
                    n_state      = ST_DONE;
                end
            end
            // final result into the output register
            ST_DONE: begin
                if (w_out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_pend_valid <= n_pend_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_res  <= n_res;
        r_out  <= n_out;
        r_pend <= n_pend;
    end

    assign o_m_valid = r_out_valid;
    assign o_m_res   = r_out;

endmodule

`default_nettype wire

/* hdl/block_cache_fifo_replacement.sv */
// top level of the block cache tag controller: controller plus a row of slot cells
// depends on bcfr_pkg, bcfr_cell and bcfr_ctrl
//
// Usage
//   Slave stream takes one request: tuser = op (access, access and mark dirty,
//   flush), tdata = block number. Master stream returns results: tuser = kind,
//   tdata = slot, write_back, victim_block; tlast marks the final result of a
//   request. A request is taken when tvalid and tready are both high.
//   An access walks the row of SLOTS cells, one cell per cycle, carrying the
//   hit, the first unused slot and the running min/max fill sequence. A new
//   request is taken only in the idle state, once the previous result has
//   moved into the output register. A request for block 0 returns a null
//   result without a walk; op 3 is dropped without a result.
//   A flush walks the row the same way and pauses at each dirty slot; it
//   returns one result per dirty slot, or one empty-flush result if none is dirty.
//   A result waits in the output register while the receiver stalls; the walk
//   of a flush pauses at a dirty slot until its writeback can be queued.
//   Synchronous active-low reset empties all slots (block 0, sequence 0,
//   clean) and clears the output valid.
`default_nettype none

module block_cache_fifo_replacement (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // request: op
    input  wire logic [bcfr_pkg::IN_USER_W-1:0]      i_s_axis_tuser,
    // request: block_num
    input  wire logic [bcfr_pkg::BLK_W-1:0]          i_s_axis_tdata,
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // result: kind
    output logic [bcfr_pkg::OUT_USER_W-1:0]          o_m_axis_tuser,
    // result: slot [3:0], write_back [4], victim_block [20:5], zero [23:21]
    output logic [bcfr_pkg::OUT_DATA_W-1:0]          o_m_axis_tdata,
    output logic                                     o_m_axis_tlast,
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready
);
    import bcfr_pkg::*;

    t_tok  w_tok [SLOTS+1];
    t_emit w_emit [SLOTS];
    t_emit w_bus;
    t_cmt  w_cmt;
    logic  w_ack;
    t_res  w_res;

    // controller
    bcfr_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .i_s_op    (t_op'(i_s_axis_tuser)),
        .i_s_blk   (i_s_axis_tdata),
        .o_tok     (w_tok[0]),
        .i_tok     (w_tok[SLOTS]),
        .i_emit    (w_bus),
        .o_ack     (w_ack),
        .o_cmt     (w_cmt),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .o_m_res   (w_res)
    );

    // row of slot cells
    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        bcfr_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IDX_W'(g)),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1]),
            .i_cmt   (w_cmt),
            .i_ack   (w_ack),
            .o_emit  (w_emit[g])
        );
    end

    // writeback bus: at most one cell drives it
    always_comb begin
        w_bus = '0;
        for (int k = 0; k < SLOTS; k++) begin
            w_bus.req = w_bus.req | w_emit[k].req;
            w_bus.idx = w_bus.idx | w_emit[k].idx;
            w_bus.blk = w_bus.blk | w_emit[k].blk;
        end
    end

    // result packing
    assign o_m_axis_tuser = w_res.kind;
    assign o_m_axis_tdata = {{PAD_W{1'b0}}, w_res.victim, w_res.wb, w_res.slot};
    assign o_m_axis_tlast = w_res.last;

endmodule

`default_nettype wire

/* hdl/bcfr_checker.sv */
// port-level checks of the block cache tag controller, bound to the top level
// depends on bcfr_pkg and block_cache_fifo_replacement
`default_nettype none

module bcfr_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic [bcfr_pkg::OUT_USER_W-1:0] o_m_axis_tuser,
    input wire logic [bcfr_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input wire logic                            o_m_axis_tlast,
    input wire logic                            o_m_axis_tvalid,
    input wire logic                            i_m_axis_tready
);
    import bcfr_pkg::*;

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) &&
            $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast))
        else $error("stalled result changed");

    // single-result kinds always end their request
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == KIND_NULL || o_m_axis_tuser == KIND_HIT ||
            o_m_axis_tuser == KIND_MISS || o_m_axis_tuser == KIND_FLUSH_NONE)
            |-> o_m_axis_tlast)
        else $error("single result without tlast");

    // no victim block without a writeback
    a_clean_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[WB_BIT] |->
            o_m_axis_tdata[VIC_MSB:VIC_LSB] == '0)
        else $error("victim block on clean result");

    // flush writebacks always request a write
    a_flush_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == KIND_FLUSH_WB |-> o_m_axis_tdata[WB_BIT])
        else $error("flush writeback without write_back");

    // null and empty-flush results carry no slot
    a_null_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == KIND_NULL ||
            o_m_axis_tuser == KIND_FLUSH_NONE) |-> o_m_axis_tdata[WB_BIT:0] == '0)
        else $error("null result carries slot or write_back");

endmodule

bind block_cache_fifo_replacement bcfr_checker u_bcfr_checker (.*);

`default_nettype wire
